@@ rtl/slt_pkg.sv @@
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions for the sorted list table
// Operation and status codes, field widths, parameter defaults and the
// control bundle that the table hands to every storage cell.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY_DEFAULT    = 64;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

    // Shift commands broadcast to every cell in the row.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_ctrl_t;

endpackage

@@ rtl/slt_cell.sv @@
// ----------------------------------------------------------------------------
// slt_cell: one storage cell of the sorted list table
// Holds one entry, compares it with the broadcast value and, on an insert
// or a remove, takes the entry of its left or right neighbour or the new value.
// ----------------------------------------------------------------------------
module slt_cell #(
    parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  slt_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   occupied,
    input  logic                   at_count,
    input  logic                   sel,
    input  logic                   prev_greater,
    input  logic [VALUE_WIDTH-1:0] prev_entry,
    input  logic [VALUE_WIDTH-1:0] succ_entry,
    output logic [VALUE_WIDTH-1:0] entry,
    output logic                   greater,
    output logic                   equal,
    output logic [VALUE_WIDTH-1:0] read_part
);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;

    assign greater   = occupied && (entry_reg > value);
    assign equal     = occupied && (entry_reg == value);
    assign entry     = entry_reg;
    assign read_part = sel ? entry_reg : '0;

    // Entries are sorted, so the cells greater than the value form one run
    // at the top; on an insert that run and the first free cell move up by
    // one, and the lowest of those cells receives the new value.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert && (greater || at_count))
        begin
            entry_next = prev_greater ? prev_entry : value;
        end
        else if (ctrl.do_remove && (greater || equal))
        begin
            entry_next = succ_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ rtl/sorted_list_table.sv @@
// Result: a result is strobed on done in the cycle after its command is taken.
// Throughput: one command per cycle; busy stays low, since every cell
// compares and shifts in the same cycle that the command is taken.
// Reset: rst_n clears the internal entry count and the done strobe at once; the
// entries themselves are not cleared, as nothing reads beyond the count.
// ----------------------------------------------------------------------------
// sorted_list_table: bounded ascending multiset with insert, remove,
// lookup and read-at-position, built as a row of comparing storage cells.
// ----------------------------------------------------------------------------
module sorted_list_table #(
    parameter int CAPACITY    = slt_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [slt_pkg::OP_W-1:0]     operation,
    input  logic [slt_pkg::VALUE_W-1:0]  value,
    input  logic [slt_pkg::POS_W-1:0]    position,
    output logic                         done,
    output logic [slt_pkg::STAT_W-1:0]   status,
    output logic [slt_pkg::VALUE_W-1:0]  read_value,
    output logic [slt_pkg::COUNT_W-1:0]  entry_count,
    output logic                         is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         done_reg;
    logic [slt_pkg::STAT_W-1:0]   status_reg;
    logic [slt_pkg::STAT_W-1:0]   status_next;
    logic [slt_pkg::VALUE_W-1:0]  read_value_reg;
    logic [slt_pkg::VALUE_W-1:0]  read_value_next;
    logic [slt_pkg::COUNT_W-1:0]  entry_count_reg;
    logic                         is_empty_reg;

    logic [VALUE_WIDTH-1:0]       key;
    logic [VALUE_WIDTH-1:0]       entries    [CAPACITY];
    logic [VALUE_WIDTH-1:0]       read_parts [CAPACITY];
    logic [CAPACITY-1:0]          greater_vec;
    logic [CAPACITY-1:0]          equal_vec;
    logic [CAPACITY-1:0]          occupied_vec;
    logic [VALUE_WIDTH-1:0]       read_word;
    logic                         found;
    logic                         full;
    logic                         in_range;
    slt_pkg::cell_ctrl_t          ctrl;

    assign busy = 1'b0;
    assign key  = VALUE_WIDTH'(value);
    assign full = (count_reg == CW'(CAPACITY));
    assign found    = |equal_vec;
    assign in_range = (32'(position) < 32'(count_reg));

    assign ctrl.do_insert = start && (operation == slt_pkg::OP_INSERT) && !full;
    assign ctrl.do_remove = start && (operation == slt_pkg::OP_REMOVE) && found;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                   prev_greater;
            logic [VALUE_WIDTH-1:0] prev_entry;
            logic [VALUE_WIDTH-1:0] succ_entry;

            assign occupied_vec[i] = (32'(count_reg) > i);

            if (i == 0)
            begin : g_first
                assign prev_greater = 1'b0;
                assign prev_entry   = '0;
            end
            else
            begin : g_inner
                assign prev_greater = greater_vec[i-1];
                assign prev_entry   = entries[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign succ_entry = '0;
            end
            else
            begin : g_body
                assign succ_entry = entries[i+1];
            end

            slt_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk          (clk),
                .ctrl         (ctrl),
                .value        (key),
                .occupied     (occupied_vec[i]),
                .at_count     (32'(count_reg) == i),
                .sel          (32'(position) == i),
                .prev_greater (prev_greater),
                .prev_entry   (prev_entry),
                .succ_entry   (succ_entry),
                .entry        (entries[i]),
                .greater      (greater_vec[i]),
                .equal        (equal_vec[i]),
                .read_part    (read_parts[i])
            );
        end
    endgenerate

    // Only the cell at the requested position drives a non-zero word.
    always_comb
    begin
        read_word = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_word = read_word | read_parts[k];
        end
    end

    always_comb
    begin
        status_next     = slt_pkg::ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        unique case (operation)
            slt_pkg::OP_INSERT:
            begin
                if (full)
                    status_next = slt_pkg::ST_FULL;
                else
                    count_next = count_reg + CW'(1);
            end
            slt_pkg::OP_REMOVE:
            begin
                if (found)
                    count_next = count_reg - CW'(1);
                else
                    status_next = slt_pkg::ST_NOT_FOUND;
            end
            slt_pkg::OP_LOOKUP:
            begin
                if (!found)
                    status_next = slt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                if (in_range)
                    read_value_next = slt_pkg::VALUE_W'(read_word);
                else
                    status_next = slt_pkg::ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= slt_pkg::COUNT_W'(count_next);
            is_empty_reg    <= (count_next == '0);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;
    assign is_empty    = is_empty_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAPACITY)
        else $error("entry count beyond capacity");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("command taken without a result strobe");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && operation == slt_pkg::OP_INSERT && !full)
        |=> (count_reg == $past(count_reg) + CW'(1)) && (status == slt_pkg::ST_OK))
        else $error("insert did not grow the table");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && operation == slt_pkg::OP_REMOVE && !found)
        |=> $stable(count_reg) && (status == slt_pkg::ST_NOT_FOUND))
        else $error("failed remove changed the table");

    generate
        for (i = 1; i < CAPACITY; i++)
        begin : g_order_chk
            a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                occupied_vec[i] |-> (entries[i-1] <= entries[i]))
                else $error("stored entries out of order");
        end
    endgenerate
`endif

endmodule

@@ dv/sorted_list_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_checker: result checker for the sorted list table
// Watches the command and result channels, keeps its own copy of the sorted
// table, predicts each result as a command is taken and compares the fields.
// ----------------------------------------------------------------------------
module sorted_list_checker
    import slt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [OP_W-1:0]     operation,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    input  logic                done,
    input  logic [STAT_W-1:0]   status,
    input  logic [VALUE_W-1:0]  read_value,
    input  logic [COUNT_W-1:0]  entry_count,
    input  logic                is_empty,
    output int                  failures,
    output int                  outstanding
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } table_result_t;

    logic [VALUE_W-1:0] table_values [CAPACITY_DEFAULT];
    int unsigned        table_size;
    table_result_t      pending_results [$];
    int                 fail_total;

    // Applies one command to the local table and returns the result it yields.
    function automatic table_result_t apply_command(
        input logic [OP_W-1:0]    op,
        input logic [VALUE_W-1:0] v,
        input logic [POS_W-1:0]   pos
    );
        table_result_t res;
        int unsigned   idx;
        res.status     = ST_OK;
        res.read_value = '0;
        idx            = 0;
        case (op)
            OP_INSERT:
            begin
                if (table_size >= CAPACITY_DEFAULT)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    // Equal values stay in arrival order: the new one goes
                    // after every value that is not greater than it.
                    while (idx < table_size && table_values[idx] <= v)
                        idx++;
                    for (int unsigned i = table_size; i > idx; i--)
                        table_values[i] = table_values[i - 1];
                    table_values[idx] = v;
                    table_size++;
                end
            end
            OP_REMOVE:
            begin
                while (idx < table_size && table_values[idx] != v)
                    idx++;
                if (idx >= table_size)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (int unsigned i = idx; i + 1 < table_size; i++)
                        table_values[i] = table_values[i + 1];
                    table_size--;
                end
            end
            OP_LOOKUP:
            begin
                while (idx < table_size && table_values[idx] != v)
                    idx++;
                if (idx >= table_size)
                    res.status = ST_NOT_FOUND;
            end
            default:
            begin
                if (pos >= table_size)
                    res.status = ST_RANGE;
                else
                    res.read_value = table_values[pos];
            end
        endcase
        res.entry_count = COUNT_W'(table_size);
        res.is_empty    = (table_size == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t observed;
        table_result_t predicted;
        if (!rst_n)
        begin
            table_size = 0;
            pending_results.delete();
            fail_total = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done !== 1'b0)
            begin
                observed = {status, read_value, entry_count, is_empty};
                if (pending_results.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result with no command outstanding: status %0d "
                                 , $realtime, status,
                                 "read_value %h entry_count %0d is_empty %b",
                                 read_value, entry_count, is_empty);
                end
                else
                begin
                    predicted = pending_results.pop_front();
                    if (observed !== predicted)
                    begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: mismatch: status %0d/%0d read_value %h/%h ",
                                     $realtime, predicted.status, observed.status,
                                     predicted.read_value, observed.read_value,
                                     "entry_count %0d/%0d is_empty %b/%b (expected/actual)",
                                     predicted.entry_count, observed.entry_count,
                                     predicted.is_empty, observed.is_empty);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                pending_results.push_back(apply_command(operation, value, position));
            failures    <= fail_total;
            outstanding <= pending_results.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the sorted list table
// Drives a short directed sequence and then alternating fill and drain
// phases of random commands, with random idle bursts, and reports the
// verdict from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------
module testbench;

    import slt_pkg::*;

    localparam int RANDOM_COMMANDS = 1700;
    localparam int CALM_TAIL       = 300;
    localparam int POOL_SIZE       = 8;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    int                 failures;
    int                 outstanding;

    int                 gap_percent;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    sorted_list_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    sorted_list_checker list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Presents one command, waits for its transfer and then may idle a while.
    task automatic send_command(
        input logic [OP_W-1:0]    op,
        input logic [VALUE_W-1:0] v,
        input logic [POS_W-1:0]   pos
    );
        operation <= op;
        value     <= v;
        position  <= pos;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gap_percent > 0 && $urandom_range(0, 99) < gap_percent)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Mostly values from a small pool, so that removes and lookups hit often.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0)
            return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, 7));
    endfunction

    initial
    begin
        int               sent;
        int               phase_len;
        int               roll;
        int               settle_cycles;
        logic [OP_W-1:0]  op;
        bit               filling;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= OP_INSERT;
        value     <= '0;
        position  <= '0;
        gap_percent = 0;
        sent        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table cases first, then a small table with duplicates and
        // both extreme values, drained back to empty.
        gap_percent = 30;
        send_command(OP_LOOKUP, 32'd0, 6'd0);
        send_command(OP_READ, 32'd0, 6'd0);
        send_command(OP_REMOVE, 32'd5, 6'd0);
        send_command(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
        send_command(OP_INSERT, 32'd0, 6'd0);
        send_command(OP_INSERT, 32'd7, 6'd0);
        send_command(OP_INSERT, 32'd7, 6'd0);
        send_command(OP_INSERT, 32'd3, 6'd0);
        send_command(OP_READ, 32'd0, 6'd0);
        send_command(OP_READ, 32'd0, 6'd4);
        send_command(OP_READ, 32'd0, 6'd5);
        send_command(OP_READ, 32'hFFFF_FFFF, 6'd63);
        send_command(OP_LOOKUP, 32'd7, 6'd0);
        send_command(OP_LOOKUP, 32'd8, 6'd0);
        send_command(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        send_command(OP_REMOVE, 32'd7, 6'd0);
        send_command(OP_READ, 32'd0, 6'd2);
        send_command(OP_REMOVE, 32'd8, 6'd0);
        send_command(OP_REMOVE, 32'd0, 6'd0);
        send_command(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
        send_command(OP_REMOVE, 32'd3, 6'd0);
        send_command(OP_REMOVE, 32'd7, 6'd0);
        send_command(OP_READ, 32'd0, 6'd0);

        // Fill phases push the table towards full and beyond; drain phases take
        // it back towards empty using the same pool of values.
        while (sent < RANDOM_COMMANDS)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
                value_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom()
                                                           : $urandom_range(0, 20);
            for (int half = 0; half < 2; half++)
            begin
                filling   = (half == 0);
                phase_len = $urandom_range(40, 160);
                case ($urandom_range(0, 2))
                    0:       gap_percent = 0;
                    1:       gap_percent = 15;
                    default: gap_percent = 50;
                endcase
                for (int k = 0; k < phase_len && sent < RANDOM_COMMANDS; k++)
                begin
                    if (sent >= RANDOM_COMMANDS - CALM_TAIL)
                        gap_percent = 0;
                    roll = $urandom_range(0, 99);
                    if (filling)
                        op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
                             (roll < 90) ? OP_LOOKUP : OP_READ;
                    else
                        op = (roll < 10) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                             (roll < 85) ? OP_LOOKUP : OP_READ;
                    send_command(op, pick_value(), pick_position());
                    sent++;
                end
            end
        end
        start <= 1'b0;

        settle_cycles = 0;
        while (outstanding != 0 && settle_cycles < 50)
        begin
            @(posedge clk);
            settle_cycles++;
        end
        repeat (4) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sorted_list_table.f @@
rtl/slt_pkg.sv
rtl/slt_cell.sv
rtl/sorted_list_table.sv
dv/sorted_list_checker.sv
dv/testbench.sv
